// ===== rtl/lwf_pkg.sv =====
// Shared constants, types and codes of the lidar wall-follow controller.
`default_nettype none

package lwf_pkg;

    // Sector geometry
    localparam int SECTOR_COUNT   = 12;
    localparam int HALF_SECTOR    = 15;
    localparam int FULL_CIRCLE    = 360;
    localparam int SECTOR_WIDTH   = FULL_CIRCLE / SECTOR_COUNT;
    localparam int SECTOR_W       = $clog2(SECTOR_COUNT);
    localparam int ANGLE_W        = 9;
    localparam int RECIP_SHIFT    = 16;
    localparam int SECTOR_RECIP   = (1 << RECIP_SHIFT) / SECTOR_WIDTH + 1;
    localparam int PROD_W         = ANGLE_W + RECIP_SHIFT;

    // Sectors the follower looks at
    localparam int SEC_FRONT       = 0;
    localparam int SEC_FRONT_LEFT  = 1;
    localparam int SEC_LEFT_FRONT  = 2;
    localparam int SEC_LEFT        = SECTOR_COUNT / 4;
    localparam int SEC_FRONT_RIGHT = SECTOR_COUNT - 1;

    // Queue sizing between and after the two halves
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Speed targets (mm/s) and turn targets (mrad/s)
    localparam int SPEED_W = 8;
    localparam int TURN_W  = 12;
    localparam logic [SPEED_W-1:0] CRUISE_SPEED  = 8'd200;
    localparam logic [SPEED_W-1:0] SEEK_SPEED    = 8'd150;
    localparam logic [SPEED_W-1:0] CORRECT_SPEED = 8'd100;
    localparam logic signed [TURN_W-1:0] NO_TURN            = 12'sd0;
    localparam logic signed [TURN_W-1:0] SEEK_TURN          = 12'sd1200;
    localparam logic signed [TURN_W-1:0] STEER_LEFT_TURN    = 12'sd1300;
    localparam logic signed [TURN_W-1:0] STEER_RIGHT_TURN   = -12'sd1200;
    localparam logic signed [TURN_W-1:0] TURN_RIGHT_RATE    = -12'sd600;

    // Q8 smoothing coefficients
    localparam int TSUM_W = 21;
    localparam int LSUM_W = 17;
    localparam logic signed [TSUM_W-1:0] K_TURN_KEEP   = 21'sd179;
    localparam logic signed [TSUM_W-1:0] K_TURN_TARGET = 21'sd26;
    localparam logic [LSUM_W-1:0]        K_LIN_KEEP    = 17'd77;
    localparam logic [LSUM_W-1:0]        K_LIN_TARGET  = 17'd128;

    typedef logic [15:0] range_t;
    typedef logic [SECTOR_W-1:0] sector_idx_t;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_TICK   = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        MODE_FOLLOW     = 2'd0,
        MODE_TURN_RIGHT = 2'd1,
        MODE_SEEK_LEFT  = 2'd2,
        MODE_HALT       = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_RANGE_MAX   = 3'd0,
        CFG_FRONT_BLOCK = 3'd1,
        CFG_DIAG_BLOCK  = 3'd2,
        CFG_DIAG_CORR   = 3'd3,
        CFG_LEFT_OPEN   = 3'd4,
        CFG_LEFT_CAPT   = 3'd5,
        CFG_CLEAR_FRONT = 3'd6,
        CFG_CLEAR_DIAG  = 3'd7
    } cfg_idx_t;

    localparam int CFG_IDX_W = 3;

    typedef struct packed {
        kind_t                kind;
        logic [ANGLE_W-1:0]   beam_angle;
        range_t               range_mm;
        logic                 first_beam;
        logic                 last_beam;
        logic                 home_reached;
    } request_t;

    typedef struct packed {
        logic [SPEED_W-1:0]        linear_speed;
        logic signed [TURN_W-1:0]  turn_rate;
        mode_t                     mode;
    } command_t;

    // Classified item passed from the front to the back
    typedef struct packed {
        kind_t       kind;
        logic        sector_hit;
        sector_idx_t sector;
        range_t      range_mm;
        logic        first_beam;
        logic        last_beam;
        logic        home_reached;
    } work_t;

    typedef struct packed {
        range_t range_max_mm;
        range_t front_block_mm;
        range_t diag_block_mm;
        range_t diag_correct_mm;
        range_t left_open_mm;
        range_t left_capture_mm;
        range_t clear_front_mm;
        range_t clear_diag_mm;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        range_max_mm:    16'd3500,
        front_block_mm:  16'd420,
        diag_block_mm:   16'd300,
        diag_correct_mm: 16'd400,
        left_open_mm:    16'd600,
        left_capture_mm: 16'd500,
        clear_front_mm:  16'd800,
        clear_diag_mm:   16'd450
    };

endpackage

`default_nettype wire

// ===== rtl/lidar_wall_follow_controller.sv =====
// Top level of the lidar wall-follow controller: config bank, front, back, result queue.
`default_nettype none

//  channel   direction  handshake            payload
//  request   in         push / full          request_t  (sample or tick)
//  command   out        empty / pop          command_t  (one per tick)
//  config    in         cfg_we               cfg_addr, cfg_wdata
//
//  One item per cycle sustained while no tick waits: each accepted item lands
//  in a two-entry front queue, and the back retires one per cycle from there.
//  A sample never waits on the result side; a tick waits only while the
//  two-entry result queue is full. A command passes through the front queue and
//  the result queue before it shows on the result ports.
//  Reset clears the queues, the follower mode, the smoothed speeds and the
//  sector minima, and loads the config defaults. No clearing pass is needed.

module lidar_wall_follow_controller (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire lwf_pkg::request_t               request,
    output logic                                 empty,
    input  wire logic                            pop,
    output lwf_pkg::command_t                    command,
    input  wire logic                            cfg_we,
    input  wire logic [lwf_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [15:0]                     cfg_wdata
);
    import lwf_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     work_valid;
    work_t    work;
    logic     work_take;
    logic     res_push;
    command_t res;
    logic     res_full;

    // Config bank: one threshold per cycle; user writes only while idle (not enforced)
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_RANGE_MAX:   cfg_next.range_max_mm    = cfg_wdata;
                CFG_FRONT_BLOCK: cfg_next.front_block_mm  = cfg_wdata;
                CFG_DIAG_BLOCK:  cfg_next.diag_block_mm   = cfg_wdata;
                CFG_DIAG_CORR:   cfg_next.diag_correct_mm = cfg_wdata;
                CFG_LEFT_OPEN:   cfg_next.left_open_mm    = cfg_wdata;
                CFG_LEFT_CAPT:   cfg_next.left_capture_mm = cfg_wdata;
                CFG_CLEAR_FRONT: cfg_next.clear_front_mm  = cfg_wdata;
                CFG_CLEAR_DIAG:  cfg_next.clear_diag_mm   = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept and classify by sector
    lwf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .request    (request),
        .work_valid (work_valid),
        .work       (work),
        .work_take  (work_take)
    );

    // Back: minima update on samples, follower step on ticks
    lwf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .work_valid (work_valid),
        .work       (work),
        .work_take  (work_take),
        .res_push   (res_push),
        .res        (res),
        .res_full   (res_full)
    );

    // Hold commands until the consumer pops them
    lwf_result_queue u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .command  (command)
    );

endmodule

`default_nettype wire

// ===== rtl/lwf_front.sv =====
// Front half: accepts items, maps beam angles to sectors, queues classified items.
`default_nettype none

module lwf_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire lwf_pkg::request_t request,
    output logic                   work_valid,
    output lwf_pkg::work_t         work,
    input  wire logic              work_take
);
    import lwf_pkg::*;

    work_t                  q_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    logic [ANGLE_W-1:0] shifted;
    logic [PROD_W-1:0]  prod;
    logic [ANGLE_W-1:0] sector_full;
    work_t              cls;
    logic               accept;

    // Rotate by half a sector so sector 0 wraps through zero
    always_comb
    begin
        shifted = request.beam_angle + ANGLE_W'(HALF_SECTOR);
        if (shifted >= ANGLE_W'(FULL_CIRCLE))
        begin
            shifted = shifted - ANGLE_W'(FULL_CIRCLE);
        end
        prod        = PROD_W'(shifted) * PROD_W'(SECTOR_RECIP);
        sector_full = ANGLE_W'(prod >> RECIP_SHIFT);
    end

    always_comb
    begin
        cls.kind         = request.kind;
        cls.sector_hit   = (request.beam_angle < ANGLE_W'(FULL_CIRCLE)) &&
                           (sector_full < ANGLE_W'(SECTOR_COUNT));
        cls.sector       = SECTOR_W'(sector_full);
        cls.range_mm     = request.range_mm;
        cls.first_beam   = request.first_beam;
        cls.last_beam    = request.last_beam;
        cls.home_reached = request.home_reached;
    end

    assign full       = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign accept     = push && !full;
    assign work_valid = (cnt_reg != '0);
    assign work       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (work_take)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (accept && !work_take)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!accept && work_take)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("front queue count overflow");

    a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        work_take |-> work_valid)
        else $error("back took from an empty front queue");

    a_cnt_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !work_take) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("front queue count did not advance on push");

endmodule

`default_nettype wire

// ===== rtl/lwf_back.sv =====
// Back half: sector minima bookkeeping and the follower state machine.
`default_nettype none

module lwf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lwf_pkg::cfg_t  cfg,
    input  wire logic           work_valid,
    input  wire lwf_pkg::work_t work,
    output logic                work_take,
    output logic                res_push,
    output lwf_pkg::command_t   res,
    input  wire logic           res_full
);
    import lwf_pkg::*;

    range_t wm_reg [SECTOR_COUNT];
    range_t wm_next [SECTOR_COUNT];
    range_t sm_reg [SECTOR_COUNT];

    mode_t                     state_reg, state_next;
    logic [SPEED_W-1:0]        sl_reg, sl_next;
    logic signed [TURN_W-1:0]  st_reg, st_next;

    logic is_tick, take_sample, take_tick;
    range_t fr, fl, frr, lf, lt;
    logic blocked, steer_left, steer_right, left_open, captured, cleared;
    logic [SPEED_W-1:0]       tgt_lin;
    logic signed [TURN_W-1:0] tgt_turn;
    logic                     smooth_en;
    logic signed [TSUM_W-1:0] tsum;
    logic [LSUM_W-1:0]        lsum;

    function automatic logic near_hit(input range_t v, input range_t limit);
        near_hit = (v < limit) && (v != '0);
    endfunction

    function automatic logic clear_or_none(input range_t v, input range_t limit);
        clear_or_none = (v > limit) || (v == '0);
    endfunction

    assign is_tick     = (work.kind == KIND_TICK);
    assign work_take   = work_valid && (!is_tick || !res_full);
    assign take_sample = work_take && !is_tick;
    assign take_tick   = work_take && is_tick;
    assign res_push    = take_tick;

    // Load on first beam, then fold the sample into its sector
    always_comb
    begin
        for (int i = 0; i < SECTOR_COUNT; i++)
        begin
            wm_next[i] = work.first_beam ? cfg.range_max_mm : wm_reg[i];
            if (work.sector_hit && (work.sector == SECTOR_W'(i)) &&
                (work.range_mm < wm_next[i]))
            begin
                wm_next[i] = work.range_mm;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SECTOR_COUNT; i++)
            begin
                wm_reg[i] <= '1;
                sm_reg[i] <= '0;
            end
        end
        else if (take_sample)
        begin
            for (int i = 0; i < SECTOR_COUNT; i++)
            begin
                wm_reg[i] <= wm_next[i];
                if (work.last_beam)
                begin
                    sm_reg[i] <= wm_next[i];
                end
            end
        end
    end

    assign fr  = sm_reg[SEC_FRONT];
    assign fl  = sm_reg[SEC_FRONT_LEFT];
    assign frr = sm_reg[SEC_FRONT_RIGHT];
    assign lf  = sm_reg[SEC_LEFT_FRONT];
    assign lt  = sm_reg[SEC_LEFT];

    assign blocked     = near_hit(fr, cfg.front_block_mm) || near_hit(fl, cfg.diag_block_mm) ||
                         near_hit(frr, cfg.diag_block_mm);
    assign steer_left  = near_hit(frr, cfg.diag_correct_mm);
    assign steer_right = near_hit(fl, cfg.diag_correct_mm);
    assign left_open   = (lf > cfg.left_open_mm) || ((lf == '0) && (lt != '0));
    assign captured    = near_hit(lf, cfg.left_capture_mm) || near_hit(fl, cfg.left_capture_mm) ||
                         near_hit(fr, cfg.left_capture_mm);
    assign cleared     = (fr > cfg.clear_front_mm) ||
                         (clear_or_none(fr, cfg.clear_front_mm) &&
                          clear_or_none(fl, cfg.clear_diag_mm) &&
                          clear_or_none(frr, cfg.clear_diag_mm));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (take_tick)
        begin
            case (state_reg)
                MODE_HALT:
                begin
                    state_next = MODE_HALT;
                end
                MODE_TURN_RIGHT:
                begin
                    if (work.home_reached)
                        state_next = MODE_HALT;
                    else if (cleared)
                        state_next = MODE_FOLLOW;
                end
                MODE_SEEK_LEFT:
                begin
                    if (work.home_reached)
                        state_next = MODE_HALT;
                    else if (captured)
                        state_next = MODE_FOLLOW;
                end
                MODE_FOLLOW:
                begin
                    if (work.home_reached)
                        state_next = MODE_HALT;
                    else if (blocked)
                        state_next = MODE_TURN_RIGHT;
                    else if (!steer_left && !steer_right && left_open)
                        state_next = MODE_SEEK_LEFT;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    // Targets and command
    always_comb
    begin
        tgt_lin          = CRUISE_SPEED;
        tgt_turn         = NO_TURN;
        smooth_en        = 1'b0;
        res.linear_speed = '0;
        res.turn_rate    = NO_TURN;
        res.mode         = state_next;
        if (work.home_reached || (state_reg == MODE_HALT))
        begin
            smooth_en = 1'b0;
        end
        else
        begin
            case (state_reg)
                MODE_TURN_RIGHT:
                begin
                    res.turn_rate = TURN_RIGHT_RATE;
                end
                MODE_SEEK_LEFT:
                begin
                    tgt_lin   = SEEK_SPEED;
                    tgt_turn  = SEEK_TURN;
                    smooth_en = 1'b1;
                end
                MODE_FOLLOW:
                begin
                    smooth_en = 1'b1;
                    if (!blocked && steer_left)
                    begin
                        tgt_lin  = CORRECT_SPEED;
                        tgt_turn = STEER_LEFT_TURN;
                    end
                    else if (!blocked && steer_right)
                    begin
                        tgt_lin  = CORRECT_SPEED;
                        tgt_turn = STEER_RIGHT_TURN;
                    end
                end
                default:
                begin
                    smooth_en = 1'b0;
                end
            endcase
            if (smooth_en)
            begin
                res.linear_speed = sl_next;
                res.turn_rate    = st_next;
            end
        end
    end

    // Q8 smoothing, floor by arithmetic shift
    assign tsum = TSUM_W'(st_reg) * K_TURN_KEEP + TSUM_W'(tgt_turn) * K_TURN_TARGET;
    assign lsum = LSUM_W'(sl_reg) * K_LIN_KEEP + LSUM_W'(tgt_lin) * K_LIN_TARGET;
    assign st_next = TURN_W'(tsum >>> 8);
    assign sl_next = SPEED_W'(lsum >> 8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MODE_FOLLOW;
            sl_reg    <= '0;
            st_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (take_tick && smooth_en)
            begin
                sl_reg <= sl_next;
                st_reg <= st_next;
            end
        end
    end

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == MODE_HALT |=> state_reg == MODE_HALT)
        else $error("halt left without reset");

    a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && (res.mode == MODE_HALT) |-> (res.linear_speed == '0) && (res.turn_rate == '0))
        else $error("halted command carries motion");

    a_turn_keeps_smooth: assert property (@(posedge clk) disable iff (!rst_n)
        take_tick && (state_reg == MODE_TURN_RIGHT) |=> $stable(sl_reg) && $stable(st_reg))
        else $error("smoothed speeds moved during right turn");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("command pushed into a full result queue");

endmodule

`default_nettype wire

// ===== rtl/lwf_result_queue.sv =====
// Two-entry queue that holds velocity commands until they are popped.
`default_nettype none

module lwf_result_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              res_push,
    input  wire lwf_pkg::command_t res,
    output logic                   res_full,
    output logic                   empty,
    input  wire logic              pop,
    output lwf_pkg::command_t      command
);
    import lwf_pkg::*;

    command_t               q_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   do_pop;

    assign res_full = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_pop   = pop && !empty;
    assign command  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (res_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (res_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!res_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result queue count overflow");

    a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(command))
        else $error("result head changed while waiting");

    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !res_push) |=> !res_full)
        else $error("result queue still full after pop");

endmodule

`default_nettype wire

// ===== verif/lidar_wall_follow_controller_test.sv =====
// Self-checking testbench for the lidar wall-follow controller: scans, ticks and register settings.
module lidar_wall_follow_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lwf_pkg::*;

    localparam int CFG_COUNT     = 1 << CFG_IDX_W;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASE_ITEMS   = 230;
    localparam int PHASE_COUNT   = 7;

    typedef logic [15:0] bank_t [CFG_COUNT];

    // Register values in index order: range max, front block, diagonal block,
    // diagonal correct, left open, left capture, clear front, clear diagonal.
    localparam bank_t DEFAULT_BANK = '{16'd3500, 16'd420, 16'd300, 16'd400,
                                       16'd600, 16'd500, 16'd800, 16'd450};
    localparam bank_t WIDE_BANK    = '{16'hFFFF, 16'd1000, 16'd800, 16'd1200,
                                       16'd300, 16'd900, 16'd1500, 16'd1000};

    // Sectors the follower reads; most random beams land in one of these.
    localparam int WATCHED [5] = '{SEC_FRONT, SEC_FRONT_LEFT, SEC_LEFT_FRONT,
                                   SEC_LEFT, SEC_FRONT_RIGHT};

    // Follower model and the store of commands still owed by the block.
    class follower_scoreboard;
        bank_t    regs;
        range_t   working_min [SECTOR_COUNT];
        range_t   visible_min [SECTOR_COUNT];
        int       smooth_lin;
        int       smooth_turn;
        bit       turning_right;
        bit       seeking_left;
        bit       halted;
        command_t expected_commands [$];
        int       failures;
        int       samples;
        int       ticks;
        int       checked;
        int       mode_hits [4];

        function new();
            regs = DEFAULT_BANK;
            foreach (working_min[i])
            begin
                working_min[i] = '1;
                visible_min[i] = '0;
            end
            smooth_lin    = 0;
            smooth_turn   = 0;
            turning_right = 1'b0;
            seeking_left  = 1'b0;
            halted        = 1'b0;
            failures      = 0;
            samples       = 0;
            ticks         = 0;
            checked       = 0;
            foreach (mode_hits[i])
                mode_hits[i] = 0;
        endfunction

        function int pending();
            return expected_commands.size();
        endfunction

        // A zero reading counts as no return, so it is never near.
        function bit near(int v, int lim);
            return v < lim && v != 0;
        endfunction

        function bit clear_or_none(int v, int lim);
            return v > lim || v == 0;
        endfunction

        function mode_t current_mode();
            if (halted)
                return MODE_HALT;
            if (turning_right)
                return MODE_TURN_RIGHT;
            if (seeking_left)
                return MODE_SEEK_LEFT;
            return MODE_FOLLOW;
        endfunction

        // Q8 smoothing; arithmetic shift on a signed int is a floor divide.
        function void blend(int tl, int ta);
            smooth_turn = (int'(K_TURN_KEEP) * smooth_turn + int'(K_TURN_TARGET) * ta) >>> 8;
            smooth_lin  = (int'(K_LIN_KEEP) * smooth_lin + int'(K_LIN_TARGET) * tl) >>> 8;
        endfunction

        function command_t steer(logic home);
            int       fr;
            int       fl;
            int       frr;
            int       lf;
            int       lt;
            int       tl;
            int       ta;
            command_t c;
            fr  = visible_min[SEC_FRONT];
            fl  = visible_min[SEC_FRONT_LEFT];
            frr = visible_min[SEC_FRONT_RIGHT];
            lf  = visible_min[SEC_LEFT_FRONT];
            lt  = visible_min[SEC_LEFT];
            tl  = int'(CRUISE_SPEED);
            ta  = int'(NO_TURN);
            if (halted || home)
            begin
                halted         = 1'b1;
                c.linear_speed = '0;
                c.turn_rate    = '0;
                c.mode         = MODE_HALT;
                return c;
            end
            if (turning_right)
            begin
                // Front beyond clearance ends it; a blank front needs both diagonals clear too.
                if (fr > regs[CFG_CLEAR_FRONT] ||
                    (fr == 0 && clear_or_none(fl, regs[CFG_CLEAR_DIAG]) &&
                     clear_or_none(frr, regs[CFG_CLEAR_DIAG])))
                    turning_right = 1'b0;
                c.linear_speed = '0;
                c.turn_rate    = TURN_RIGHT_RATE;
                c.mode         = current_mode();
                return c;
            end
            if (seeking_left)
            begin
                blend(int'(SEEK_SPEED), int'(SEEK_TURN));
                if (near(lf, regs[CFG_LEFT_CAPT]) || near(fl, regs[CFG_LEFT_CAPT]) ||
                    near(fr, regs[CFG_LEFT_CAPT]))
                    seeking_left = 1'b0;
            end
            else
            begin
                if (near(fr, regs[CFG_FRONT_BLOCK]) || near(fl, regs[CFG_DIAG_BLOCK]) ||
                    near(frr, regs[CFG_DIAG_BLOCK]))
                    turning_right = 1'b1;
                else if (near(frr, regs[CFG_DIAG_CORR]))
                begin
                    ta = int'(STEER_LEFT_TURN);
                    tl = int'(CORRECT_SPEED);
                end
                else if (near(fl, regs[CFG_DIAG_CORR]))
                begin
                    ta = int'(STEER_RIGHT_TURN);
                    tl = int'(CORRECT_SPEED);
                end
                else if (lf > regs[CFG_LEFT_OPEN] || (lf == 0 && lt != 0))
                    seeking_left = 1'b1;
                // Entering a mode still blends toward the targets chosen above.
                blend(tl, ta);
            end
            c.linear_speed = smooth_lin[SPEED_W-1:0];
            c.turn_rate    = smooth_turn[TURN_W-1:0];
            c.mode         = current_mode();
            return c;
        endfunction

        function void take_request(request_t r);
            int sec;
            if (r.kind == KIND_SAMPLE)
            begin
                samples++;
                if (r.first_beam)
                    foreach (working_min[i])
                        working_min[i] = regs[CFG_RANGE_MAX];
                if (r.beam_angle < FULL_CIRCLE)
                begin
                    sec = ((int'(r.beam_angle) + HALF_SECTOR) % FULL_CIRCLE) / SECTOR_WIDTH;
                    if (sec < SECTOR_COUNT && r.range_mm < working_min[sec])
                        working_min[sec] = r.range_mm;
                end
                if (r.last_beam)
                    visible_min = working_min;
            end
            else
            begin
                ticks++;
                expected_commands.push_back(steer(r.home_reached));
            end
        endfunction

        function void check_command(command_t got);
            command_t want;
            if (expected_commands.size() == 0)
            begin
                failures++;
                $error("unexpected command: linear_speed %0d turn_rate %0d mode %0d",
                       got.linear_speed, got.turn_rate, got.mode);
                return;
            end
            want = expected_commands.pop_front();
            checked++;
            mode_hits[want.mode]++;
            if (got.linear_speed !== want.linear_speed)
            begin
                failures++;
                $error("linear_speed: expected %0d, got %0d", want.linear_speed,
                       got.linear_speed);
            end
            if (got.turn_rate !== want.turn_rate)
            begin
                failures++;
                $error("turn_rate: expected %0d, got %0d", want.turn_rate, got.turn_rate);
            end
            if (got.mode !== want.mode)
            begin
                failures++;
                $error("mode: expected %0d, got %0d", want.mode, got.mode);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    request_t             request;
    logic                 empty;
    logic                 pop;
    command_t             command;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [15:0]          cfg_wdata;

    follower_scoreboard sb = new();

    bit calm;          // set for the last part of the run: no idling on either side
    bit halt_armed;    // ticks may carry home_reached only once this is set
    bit hold_pending;  // asks the receiver for one long hold-off
    int sent;
    int settings_used;
    int cycle_count;

    lidar_wall_follow_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .command   (command),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a missing command ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("run timed out with %0d commands outstanding", sb.pending());
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: check each popped command, idle in short bursts, and once hold
    // off long enough for both internal queues to fill and raise full.
    initial
    begin
        int gap;
        int hold_left;
        gap       = 0;
        hold_left = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_command(command);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 5) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    function automatic request_t mk_sample(int angle, int rng, bit first, bit last);
        request_t r;
        r.kind         = KIND_SAMPLE;
        r.beam_angle   = angle[ANGLE_W-1:0];
        r.range_mm     = rng[15:0];
        r.first_beam   = first;
        r.last_beam    = last;
        r.home_reached = 1'($urandom_range(0, 1));  // ignored on a sample
        return r;
    endfunction

    // Angle, range and beam flags mean nothing on a tick; randomize them anyway.
    function automatic request_t mk_tick(bit home);
        request_t r;
        r.kind         = KIND_TICK;
        r.beam_angle   = ANGLE_W'($urandom_range(0, (1 << ANGLE_W) - 1));
        r.range_mm     = 16'($urandom_range(0, 65535));
        r.first_beam   = 1'($urandom_range(0, 1));
        r.last_beam    = 1'($urandom_range(0, 1));
        r.home_reached = home;
        return r;
    endfunction

    // Offer one item, optionally after a short idle burst, and hold it until taken.
    task automatic send_item(request_t r);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        push    <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (full);
        sb.take_request(r);
        sent++;
    endtask

    // Stop offering, let every owed command come out, then let trailing samples settle.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all registers back to back; only called with the block idle.
    task automatic apply_bank(bank_t b);
        cfg_idx_t idx;
        idx = idx.first();
        do
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= b[idx];
            @(posedge clk);
            sb.regs[idx] = b[idx];
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // One scan with random content: pick a level per sector, spray beams mostly into
    // the watched sectors, then run a few ticks. Now and then break the scan flags
    // or throw in an out-of-range angle.
    task automatic run_scan();
        int level [SECTOR_COUNT];
        int beams;
        int sec;
        int angle;
        int rng;
        bit broken;
        bit first;
        bit last;
        beams  = $urandom_range(3, 20);
        broken = ($urandom_range(0, 9) == 0);
        foreach (level[i])
        begin
            case ($urandom_range(0, 7))
                0:       level[i] = 0;
                1:       level[i] = $urandom_range(0, 65535);
                2, 3:    level[i] = $urandom_range(1, 500);
                4, 5:    level[i] = $urandom_range(300, 1000);
                default: level[i] = -1;  // no beam: beams aimed here go to the rear sector instead
            endcase
        end
        for (int n = 0; n < beams; n++)
        begin
            if ($urandom_range(0, 3) != 0)
                sec = WATCHED[$urandom_range(0, 4)];
            else
                sec = $urandom_range(0, SECTOR_COUNT - 1);
            if (level[sec] < 0)
            begin
                sec = SECTOR_COUNT / 2;
                rng = $urandom_range(0, 65535);
            end
            else if (level[sec] == 0)
                rng = 0;
            else
            begin
                rng = level[sec] + $urandom_range(0, 40);
                if (rng > 65535)
                    rng = 65535;
            end
            angle = (sec * SECTOR_WIDTH + FULL_CIRCLE - HALF_SECTOR +
                     $urandom_range(0, SECTOR_WIDTH - 1)) % FULL_CIRCLE;
            if ($urandom_range(0, 11) == 0)
            begin
                angle = $urandom_range(FULL_CIRCLE, (1 << ANGLE_W) - 1);
                rng   = $urandom_range(0, 65535);
            end
            first = (n == 0);
            last  = (n == beams - 1);
            if (broken)
            begin
                first = first ^ ($urandom_range(0, 2) == 0);
                last  = last ^ ($urandom_range(0, 2) == 0);
            end
            send_item(mk_sample(angle, rng, first, last));
        end
        repeat ($urandom_range(1, 4))
            send_item(mk_tick(halt_armed && $urandom_range(0, 29) == 0));
    endtask

    initial
    begin
        bank_t plan;
        int    goal;
        rst_n        = 1'b0;
        push        <= 1'b0;
        request     <= '0;
        cfg_we      <= 1'b0;
        cfg_addr    <= CFG_RANGE_MAX;
        cfg_wdata   <= '0;
        calm         = 1'b0;
        halt_armed   = 1'b0;
        hold_pending = 1'b0;
        sent         = 0;
        settings_used = 1;
        cycle_count  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings.
        send_item(mk_tick(1'b0));                      // tick before any scan: all blank
        send_item(mk_sample(0, 0, 1'b1, 1'b0));        // zero reading in front
        send_item(mk_sample(359, 65535, 1'b0, 1'b0));
        send_item(mk_sample(14, 700, 1'b0, 1'b0));     // top edge of the front sector
        send_item(mk_sample(15, 350, 1'b0, 1'b0));     // bottom edge of front-left
        send_item(mk_sample(344, 380, 1'b0, 1'b0));    // top edge of front-right
        send_item(mk_sample(345, 200, 1'b0, 1'b0));    // wraps into the front sector
        send_item(mk_sample(511, 1, 1'b0, 1'b1));      // bad angle, commit still acts
        send_item(mk_tick(1'b0));                      // front-right close: steer left
        send_item(mk_sample(360, 50, 1'b1, 1'b1));     // bad angle with load and commit
        send_item(mk_tick(1'b0));                      // left-front open: enter seek
        send_item(mk_tick(1'b0));                      // inside seek
        send_item(mk_sample(60, 450, 1'b1, 1'b1));
        send_item(mk_tick(1'b0));                      // wall captured: leave seek
        send_item(mk_sample(30, 350, 1'b1, 1'b1));
        send_item(mk_tick(1'b0));                      // front-left close: steer right
        send_item(mk_sample(0, 100, 1'b1, 1'b1));
        send_item(mk_tick(1'b0));                      // front blocked: enter right turn
        send_item(mk_tick(1'b0));                      // still blocked: keep turning
        send_item(mk_sample(180, 5, 1'b1, 1'b1));
        send_item(mk_tick(1'b0));                      // front clear: turn ends
        send_item(mk_sample(90, 1000, 1'b1, 1'b0));
        send_item(mk_sample(60, 0, 1'b0, 1'b1));       // blank left-front, wall on the left
        send_item(mk_tick(1'b0));                      // enter seek on the blank reading

        // Random part, one register setting per phase; each phase starts idle.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain();
            case (phase)
                0: plan = DEFAULT_BANK;
                1: foreach (plan[i]) plan[i] = 16'h0000;
                2: foreach (plan[i]) plan[i] = 16'hFFFF;
                3: plan = WIDE_BANK;
                4:
                begin
                    plan = DEFAULT_BANK;
                    plan[CFG_RANGE_MAX] = 16'h0000;
                end
                5:
                begin
                    foreach (plan[i])
                        plan[i] = 16'($urandom_range(0, 2000));
                    plan[CFG_RANGE_MAX] = 16'($urandom_range(0, 65535));
                end
                default:
                begin
                    plan       = DEFAULT_BANK;
                    calm       = 1'b1;
                    halt_armed = 1'b1;
                end
            endcase
            apply_bank(plan);
            if (phase == 3)
            begin
                // Keep offering ticks while the receiver holds off: full must rise.
                hold_pending = 1'b1;
                repeat (30) send_item(mk_tick(1'b0));
            end
            goal = sent + PHASE_ITEMS / 2;
            while (sent < goal)
                run_scan();
            if (halt_armed)
                send_item(mk_tick(1'b1));              // make sure the halt is reached
            goal = sent + PHASE_ITEMS / 2;
            while (sent < goal)
                run_scan();
        end

        drain();
        $display("run covered %0d samples and %0d ticks over %0d register settings",
                 sb.samples, sb.ticks, settings_used);
        $display("commands checked %0d: follow %0d, right turn %0d, left seek %0d, halt %0d",
                 sb.checked, sb.mode_hits[MODE_FOLLOW], sb.mode_hits[MODE_TURN_RIGHT],
                 sb.mode_hits[MODE_SEEK_LEFT], sb.mode_hits[MODE_HALT]);
        if (sb.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/lwf_pkg.sv
rtl/lwf_front.sv
rtl/lwf_back.sv
rtl/lwf_result_queue.sv
rtl/lidar_wall_follow_controller.sv
verif/lidar_wall_follow_controller_test.sv
